[src/siq_pkg.sv]
// Package for the sorted insertion queue: beat payload types, the stored entry
// type, operation and status codes, and sequencer states.
// No dependencies; used by siq_store and sorted_insertion_queue_top.
package siq_pkg;

   // Operation codes carried in the request beat.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_POP    = 1'b1;

   // Result status codes.
   localparam logic [1:0] STATUS_INSERTED = 2'd0;
   localparam logic [1:0] STATUS_POPPED   = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_EMPTY    = 2'd3;

   // Request beat.
   typedef struct packed {
      logic        op;
      logic [15:0] customer_id;
      logic [7:0]  item_count;
      logic [2:0]  customer_type;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] out_customer_id;
      logic [7:0]  out_item_count;
      logic [2:0]  out_customer_type;
      logic [4:0]  occupancy;
   } rsp_type;

   // One stored list entry.
   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  count;
      logic [2:0]  ctype;
   } entry_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SHIFT,
      ST_PLACE,
      ST_POP_HEAD,
      ST_POP_SHIFT
   } state_type;

endpackage

[src/siq_store.sv]
// Entry memory for the sorted insertion queue: one write port and one read
// port with registered read data. Depends on siq_pkg for the entry type.
module siq_store #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  siq_pkg::entry_type    wr_data,
   input  logic [AW-1:0]         rd_addr,
   output siq_pkg::entry_type    rd_data
);

   siq_pkg::entry_type mem [DEPTH];
   siq_pkg::entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data registered.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/sorted_insertion_queue_top.sv]
// Top level of the sorted insertion queue: command interface, sequencer and
// the single key comparator. Depends on siq_pkg and siq_store.
//
//   channel   ports                          direction  handshake
//   request   start, busy, req_data          in         start high, busy low
//   result    rsp_strobe, rsp_data           out        strobe, one cycle
//   config    csr_we, csr_wdata              in         write enable
//
// An insert walks from the head to its place, moves any entries behind it one
// place toward the tail and writes the new entry; a pop reports the head and
// moves the rest toward the head. A dropped insert or a pop on an empty list is
// reported from idle. The memory ports compare or move one entry per cycle.
// Reset is synchronous and empties the list; entry contents are not cleared.
// The receiver cannot stall: each result shows for exactly one cycle.
module sorted_insertion_queue_top #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  siq_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output siq_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic              csr_wdata
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   siq_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      pos_ff, pos_in;
   siq_pkg::req_type   item_ff, item_in;
   logic               sort_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   siq_pkg::rsp_type   rsp_ff, rsp_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   siq_pkg::entry_type wr_data;
   logic [AW-1:0]      rd_addr;
   siq_pkg::entry_type rd_data;

   logic               accept;
   logic [CW-1:0]      idx_inc;
   logic [CW-1:0]      idx_dec;
   logic               key_greater;
   siq_pkg::entry_type new_entry;

   // Sort key: item count, or customer type widened to the count width.
   function automatic logic [7:0] key_of(input logic [7:0] count,
                                         input logic [2:0] ctype,
                                         input logic       by_type);
      key_of = by_type ? {5'd0, ctype} : count;
   endfunction

   assign accept  = start && (state_ff == siq_pkg::ST_IDLE);
   assign busy    = (state_ff != siq_pkg::ST_IDLE);
   assign idx_inc = idx_ff + CW'(1);
   assign idx_dec = idx_ff - CW'(1);

   assign new_entry = '{id: item_ff.customer_id, count: item_ff.item_count,
                        ctype: item_ff.customer_type};

   // The single comparator, used by the search: stored entry key against the new key.
   assign key_greater = key_of(rd_data.count, rd_data.ctype, sort_ff)
                        > key_of(item_ff.item_count, item_ff.customer_type, sort_ff);

   // Entry memory.
   siq_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= siq_pkg::ST_IDLE;
         fill_ff      <= '0;
         sort_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            sort_ff <= csr_wdata;
         end
      end
   end

   // Payload and index registers.
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      pos_ff  <= pos_in;
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   // Sequencer: next state, memory port control and result beat.
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      item_in      = item_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_inc[AW-1:0];
      wr_data      = rd_data;
      rd_addr      = '0;

      unique case (state_ff)
         siq_pkg::ST_IDLE: begin
            if (accept) begin
               item_in = req_data;
               idx_in  = '0;
               rsp_in  = '0;
               if (req_data.op == siq_pkg::OP_INSERT) begin
                  if (fill_ff == CW'(DEPTH)) begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.status    = siq_pkg::STATUS_FULL;
                     rsp_in.occupancy = 5'(fill_ff);
                  end else if (fill_ff == '0) begin
                     pos_in   = '0;
                     state_in = siq_pkg::ST_PLACE;
                  end else begin
                     state_in = siq_pkg::ST_SEARCH;
                  end
               end else begin
                  if (fill_ff == '0) begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.status    = siq_pkg::STATUS_EMPTY;
                     rsp_in.occupancy = 5'(fill_ff);
                  end else begin
                     state_in = siq_pkg::ST_POP_HEAD;
                  end
               end
            end
         end

         // Walk from the head to the first entry whose key is greater, or to the tail.
         siq_pkg::ST_SEARCH: begin
            if (key_greater) begin
               pos_in   = idx_ff;
               idx_in   = fill_ff - CW'(1);
               rd_addr  = idx_in[AW-1:0];
               state_in = siq_pkg::ST_SHIFT;
            end else if (idx_inc == fill_ff) begin
               pos_in   = fill_ff;
               state_in = siq_pkg::ST_PLACE;
            end else begin
               idx_in  = idx_inc;
               rd_addr = idx_inc[AW-1:0];
            end
         end

         // Move entries one place toward the tail, from the tail down.
         siq_pkg::ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_inc[AW-1:0];
            wr_data = rd_data;
            if (idx_ff == pos_ff) begin
               state_in = siq_pkg::ST_PLACE;
            end else begin
               idx_in  = idx_dec;
               rd_addr = idx_dec[AW-1:0];
            end
         end

         // Write the new entry into its slot and report.
         siq_pkg::ST_PLACE: begin
            wr_en            = 1'b1;
            wr_addr          = pos_ff[AW-1:0];
            wr_data          = new_entry;
            fill_in          = fill_ff + CW'(1);
            rsp_valid_in     = 1'b1;
            rsp_in           = '0;
            rsp_in.status    = siq_pkg::STATUS_INSERTED;
            rsp_in.occupancy = 5'(fill_in);
            state_in         = siq_pkg::ST_IDLE;
         end

         // Head entry is on the read port: report it, then close the gap.
         siq_pkg::ST_POP_HEAD: begin
            fill_in                  = fill_ff - CW'(1);
            rsp_valid_in             = 1'b1;
            rsp_in.status            = siq_pkg::STATUS_POPPED;
            rsp_in.out_customer_id   = rd_data.id;
            rsp_in.out_item_count    = rd_data.count;
            rsp_in.out_customer_type = rd_data.ctype;
            rsp_in.occupancy         = 5'(fill_in);
            if (fill_ff == CW'(1)) begin
               state_in = siq_pkg::ST_IDLE;
            end else begin
               idx_in   = CW'(1);
               rd_addr  = AW'(1);
               state_in = siq_pkg::ST_POP_SHIFT;
            end
         end

         // Move entries one place toward the head.
         siq_pkg::ST_POP_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_dec[AW-1:0];
            wr_data = rd_data;
            if (idx_ff == fill_ff) begin
               state_in = siq_pkg::ST_IDLE;
            end else begin
               idx_in  = idx_inc;
               rd_addr = idx_inc[AW-1:0];
            end
         end

         default: begin
            state_in = siq_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

`ifndef NO_ASSERTIONS
   // The fill level never passes the list depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("fill level above depth");

   // A reported occupancy matches the fill level it leaves behind.
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.occupancy == 5'(fill_ff))
      else $error("occupancy does not match fill level");

   // An accepted beat either reports at once or keeps the block busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted beat made no progress");

   // Entry writes go no further than the first free slot after the stored list.
   a_write_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> {1'b0, wr_addr} <= {1'b0, fill_ff})
      else $error("entry write beyond fill level");
`endif

endmodule

[bench/tb.sv]
// Self-checking bench for sorted_insertion_queue_top: a directed table, then random phases
// of insert and pop beats, each result checked against a shadow sorted list or a typed-in one.
// Depends on siq_pkg and the RTL of sorted_insertion_queue_top.
`timescale 1ns / 100ps

module tb;

   localparam int QUEUE_DEPTH   = 16;
   localparam int STALL_LIMIT   = 600;
   localparam int DRAIN_CYCLES  = 40;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_BEATS   = 96;

   // One row of the directed table; pinned rows carry a typed-in expected result.
   typedef struct {
      bit               wr_cfg;
      bit               cfg_val;
      siq_pkg::req_type beat;
      bit               pinned;
      siq_pkg::rsp_type exp;
   } plan_row;

   // Expected result pinned to a request beat, or none.
   typedef struct {
      bit               pinned;
      siq_pkg::rsp_type exp;
   } pin_entry;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   siq_pkg::req_type req_data;
   logic             rsp_strobe;
   siq_pkg::rsp_type rsp_data;
   logic             csr_we;
   logic             csr_wdata;

   // Shadow copy of the sorted list and of the key select.
   siq_pkg::entry_type model_slots[QUEUE_DEPTH];
   int                 model_fill;
   bit                 model_by_type;

   siq_pkg::rsp_type pending_results[$];
   pin_entry         pinned_results[$];
   plan_row          directed_plan[$];
   int               error_count;
   int               stall_cycles;

   sorted_insertion_queue_top #(
      .DEPTH(QUEUE_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Prints one line per failure and counts every one.
   task automatic flag_error(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         flag_error($sformatf("%s got %0h, expected %0h", name, got, want));
      end
   endtask

   function automatic logic [7:0] sort_key(input siq_pkg::entry_type e);
      return model_by_type ? {5'd0, e.ctype} : e.count;
   endfunction

   function automatic siq_pkg::req_type make_beat(input logic op, input logic [15:0] id,
                                                  input logic [7:0] cnt,
                                                  input logic [2:0] typ);
      siq_pkg::req_type b;
      b.op            = op;
      b.customer_id   = id;
      b.item_count    = cnt;
      b.customer_type = typ;
      return b;
   endfunction

   function automatic siq_pkg::rsp_type make_rsp(input logic [1:0] st,
                                                 input logic [15:0] id,
                                                 input logic [7:0] cnt,
                                                 input logic [2:0] typ,
                                                 input logic [4:0] occ);
      siq_pkg::rsp_type r;
      r.status            = st;
      r.out_customer_id   = id;
      r.out_item_count    = cnt;
      r.out_customer_type = typ;
      r.occupancy         = occ;
      return r;
   endfunction

   // Applies one request beat to the shadow list and works out its result.
   task automatic predict_queue_op(input siq_pkg::req_type b, output siq_pkg::rsp_type r);
      siq_pkg::entry_type ent;
      int                 slot;
      int                 i;
      r = '0;
      if (b.op == siq_pkg::OP_INSERT) begin
         if (model_fill >= QUEUE_DEPTH) begin
            r.status = siq_pkg::STATUS_FULL;
         end else begin
            ent.id    = b.customer_id;
            ent.count = b.item_count;
            ent.ctype = b.customer_type;
            // The new entry goes ahead of the first stored entry with a larger key.
            slot = model_fill;
            for (i = 0; i < model_fill; i++) begin
               if (slot == model_fill && sort_key(model_slots[i]) > sort_key(ent)) begin
                  slot = i;
               end
            end
            for (i = model_fill; i > slot; i--) begin
               model_slots[i] = model_slots[i - 1];
            end
            model_slots[slot] = ent;
            model_fill++;
            r.status = siq_pkg::STATUS_INSERTED;
         end
      end else if (model_fill == 0) begin
         r.status = siq_pkg::STATUS_EMPTY;
      end else begin
         ent = model_slots[0];
         for (i = 1; i < model_fill; i++) begin
            model_slots[i - 1] = model_slots[i];
         end
         model_fill--;
         r.status            = siq_pkg::STATUS_POPPED;
         r.out_customer_id   = ent.id;
         r.out_item_count    = ent.count;
         r.out_customer_type = ent.ctype;
      end
      r.occupancy = model_fill[4:0];
   endtask

   // Tracks accepted request beats, checks result beats and counts stalled cycles.
   always @(posedge clock) begin : result_check
      siq_pkg::rsp_type predicted;
      siq_pkg::rsp_type wanted;
      pin_entry         pin;
      bit               took;
      took = 1'b0;
      if (reset) begin
         model_fill    = 0;
         model_by_type = 1'b0;
         stall_cycles  = 0;
      end else begin
         if (csr_we) begin
            model_by_type = csr_wdata;
            took = 1'b1;
         end
         if (start && !busy) begin
            predict_queue_op(req_data, predicted);
            pin = pinned_results.pop_front();
            pending_results.push_back(pin.pinned ? pin.exp : predicted);
            took = 1'b1;
         end
         if (rsp_strobe) begin
            took = 1'b1;
            if (pending_results.size() == 0) begin
               flag_error("result beat with no request outstanding");
            end else begin
               wanted = pending_results.pop_front();
               check_field("status", 16'(rsp_data.status), 16'(wanted.status));
               check_field("out_customer_id", rsp_data.out_customer_id,
                           wanted.out_customer_id);
               check_field("out_item_count", 16'(rsp_data.out_item_count),
                           16'(wanted.out_item_count));
               check_field("out_customer_type", 16'(rsp_data.out_customer_type),
                           16'(wanted.out_customer_type));
               check_field("occupancy", 16'(rsp_data.occupancy), 16'(wanted.occupancy));
            end
         end
         stall_cycles = took ? 0 : stall_cycles + 1;
      end
   end

   // Ends the run if no beat of any kind moves for too long.
   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("sorted_insertion_queue_top verification failed");
      $finish;
   end

   // Raises start with a beat and holds it until the block takes it.
   task automatic issue_beat(input siq_pkg::req_type b, input bit pinned,
                             input siq_pkg::rsp_type exp);
      pin_entry pin;
      pin.pinned = pinned;
      pin.exp    = exp;
      pinned_results.push_back(pin);
      req_data <= b;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // Idles the request side for a random number of cycles after a beat.
   task automatic pause_random(input bit allow_gaps);
      int gap;
      gap = allow_gaps ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits until every result has come back and the block is idle.
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0 || busy);
   endtask

   task automatic write_sort_mode(input bit by_type);
      csr_we    <= 1'b1;
      csr_wdata <= by_type;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic add_row(input bit wr_cfg, input bit cfg_val, input siq_pkg::req_type beat,
                          input bit pinned, input siq_pkg::rsp_type exp);
      plan_row row;
      row.wr_cfg  = wr_cfg;
      row.cfg_val = cfg_val;
      row.beat    = beat;
      row.pinned  = pinned;
      row.exp     = exp;
      directed_plan.push_back(row);
   endtask

   // Directed table: empty pop, field extremes, ties, full list, key change with entries held.
   task automatic build_directed();
      int               i;
      siq_pkg::rsp_type none;
      none = '0;
      add_row(0, 0, make_beat(siq_pkg::OP_POP, 16'h0000, 8'h00, 3'd0), 1,
              make_rsp(siq_pkg::STATUS_EMPTY, 16'h0000, 8'h00, 3'd0, 5'd0));
      add_row(0, 0, make_beat(siq_pkg::OP_INSERT, 16'hFFFF, 8'hFF, 3'd7), 1,
              make_rsp(siq_pkg::STATUS_INSERTED, 16'h0000, 8'h00, 3'd0, 5'd1));
      add_row(0, 0, make_beat(siq_pkg::OP_INSERT, 16'h0000, 8'h00, 3'd0), 1,
              make_rsp(siq_pkg::STATUS_INSERTED, 16'h0000, 8'h00, 3'd0, 5'd2));
      // Fill up with repeated counts so that ties must keep arrival order.
      for (i = 0; i < 14; i++) begin
         add_row(0, 0, make_beat(siq_pkg::OP_INSERT, 16'(16'h1000 + i),
                                 8'h20 + 8'(i % 3) * 8'h40, 3'(i % 8)), 1,
                 make_rsp(siq_pkg::STATUS_INSERTED, 16'h0000, 8'h00, 3'd0, 5'(i + 3)));
      end
      add_row(0, 0, make_beat(siq_pkg::OP_INSERT, 16'hAAAA, 8'h01, 3'd0), 1,
              make_rsp(siq_pkg::STATUS_FULL, 16'h0000, 8'h00, 3'd0, 5'd16));
      add_row(0, 0, make_beat(siq_pkg::OP_POP, 16'hFFFF, 8'hFF, 3'd7), 1,
              make_rsp(siq_pkg::STATUS_POPPED, 16'h0000, 8'h00, 3'd0, 5'd15));
      add_row(0, 0, make_beat(siq_pkg::OP_POP, 16'h0000, 8'h00, 3'd0), 0, none);
      // Switch the key to customer type while entries sorted by count stay stored.
      add_row(1, 1, make_beat(siq_pkg::OP_INSERT, 16'h5555, 8'h00, 3'd0), 0, none);
      add_row(0, 0, make_beat(siq_pkg::OP_INSERT, 16'h5556, 8'hFF, 3'd7), 0, none);
      for (i = 0; i < 3; i++) begin
         add_row(0, 0, make_beat(siq_pkg::OP_POP, 16'($urandom), 8'($urandom),
                                 3'($urandom)),
                 0, none);
      end
   endtask

   // Random beat with content that often repeats keys so that ties are common.
   function automatic siq_pkg::req_type random_beat(input int insert_pct);
      logic [7:0] cnt;
      if ($urandom_range(0, 2) == 0) begin
         cnt = 8'($urandom_range(0, 255));
      end else begin
         cnt = 8'($urandom_range(0, 3) * 8'h55);
      end
      return make_beat(($urandom_range(1, 100) <= insert_pct) ?
                       siq_pkg::OP_INSERT : siq_pkg::OP_POP,
                       16'($urandom), cnt, 3'($urandom_range(0, 7)));
   endfunction

   // Main sequence: reset, directed table, then random phases with a key setting each.
   initial begin
      plan_row          row;
      siq_pkg::rsp_type none;
      int               sent;
      int               burst;
      int               insert_pct;
      bit               gaps_on;
      int               phase;
      int               k;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_we      = 1'b0;
      csr_wdata   = 1'b0;
      error_count = 0;
      none        = '0;
      build_directed();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < directed_plan.size(); k++) begin
         row = directed_plan[k];
         if (row.wr_cfg) begin
            settle();
            write_sort_mode(row.cfg_val);
         end
         issue_beat(row.beat, row.pinned, row.exp);
         pause_random(1'b1);
      end

      // Bursts lean toward inserts, toward pops or neither, so the list keeps reaching full and empty.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         write_sort_mode((phase < 2) ? phase[0] : 1'($urandom_range(0, 1)));
         sent = 0;
         while (sent < PHASE_BEATS) begin
            burst = $urandom_range(1, 24);
            case ($urandom_range(0, 2))
               0: insert_pct = 85;
               1: insert_pct = 15;
               default: insert_pct = 50;
            endcase
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat (burst) begin
               issue_beat(random_beat(insert_pct), 1'b0, none);
               pause_random(gaps_on);
               sent++;
            end
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         flag_error($sformatf("%0d expected results never arrived",
                              pending_results.size()));
      end
      if (error_count == 0) begin
         $display("sorted_insertion_queue_top verification clean");
      end else begin
         $display("sorted_insertion_queue_top verification failed");
      end
      $finish;
   end

endmodule
